// ===== rtl/core/srs_pkg.sv =====
// ----------------------------------------------------------------------------
// srs_pkg: shared definitions for the sorted range set
// Sizes, function codes, entry layout, compare flags and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package srs_pkg;

   localparam int MAX_RANGES = 1024;
   localparam int ADDR_W     = $clog2(MAX_RANGES);
   localparam int CNT_W      = $clog2(MAX_RANGES + 1);
   localparam int DATA_W     = 32;
   localparam int FUNC_W     = 2;
   localparam int SLOT_W     = 10;
   localparam int ENTRY_W    = 2 * DATA_W;

   localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   typedef struct packed {
      logic [DATA_W-1:0] low;
      logic [DATA_W-1:0] high;
   } srs_entry_type;

   typedef struct packed {
      logic start_le;    // entry low <= index
      logic start_next;  // index + 1 == entry low
      logic high_ge;     // entry high >= index
      logic high_next;   // entry high + 1 == index
   } srs_cmp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_DECIDE,
      ST_SHUP_RD,
      ST_SHUP_WR,
      ST_INS,
      ST_SHDN_RD,
      ST_SHDN_WR,
      ST_READ_RD,
      ST_READ_WAIT,
      ST_DONE
   } srs_state_type;

endpackage

`default_nettype wire

// ===== rtl/core/srs_ram.sv =====
// ----------------------------------------------------------------------------
// srs_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/srs_cmp.sv =====
// ----------------------------------------------------------------------------
// srs_cmp: shared compare unit
// Compares the item index against a range start and a range end.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_cmp (
   input  wire logic [srs_pkg::DATA_W-1:0] index_value,
   input  wire logic [srs_pkg::DATA_W-1:0] range_start,
   input  wire logic [srs_pkg::DATA_W-1:0] range_stop,
   output srs_pkg::srs_cmp_type            flags
);
   import srs_pkg::*;

   always_comb begin
      flags.start_le   = (range_start <= index_value);
      flags.start_next = ((index_value + DATA_W'(1)) == range_start);
      flags.high_ge    = (range_stop >= index_value);
      flags.high_next  = ((range_stop + DATA_W'(1)) == index_value);
   end

endmodule

`default_nettype wire

// ===== rtl/core/sorted_range_set_insert.sv =====
// ----------------------------------------------------------------------------
// sorted_range_set_insert: sorted set of disjoint index ranges
// Add, read and clear of an ascending list of closed ranges with coalescing.
// ----------------------------------------------------------------------------
// One item at a time: busy is high from the accepting edge until the cycle
// after rsp_strobe. The ranges live in a RAM with one write and one registered
// read port, and the scan, the shifts and the read all go through that read port.
// A clear or unused code goes straight to the result; a read skips the RAM when
// the slot is not below the count. An add scans the ranges below the index, then
// a new range shifts the ranges above it up and a merge of two neighbors shifts
// them down. The result is shown for exactly one cycle and cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_range_set_insert (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [srs_pkg::FUNC_W-1:0] req_func,
   input  wire logic [srs_pkg::DATA_W-1:0] req_index_value,
   input  wire logic [srs_pkg::SLOT_W-1:0] req_slot,
   output logic                            rsp_strobe,
   output logic      [srs_pkg::DATA_W-1:0] rsp_range_low,
   output logic      [srs_pkg::DATA_W-1:0] rsp_range_high,
   output logic      [srs_pkg::CNT_W-1:0]  rsp_range_count,
   output logic                            rsp_dropped,
   output logic                            rsp_slot_valid
);
   import srs_pkg::*;

   srs_state_type state_ff, state_in;

   logic [FUNC_W-1:0] func_ff, func_in;
   logic [DATA_W-1:0] v_ff, v_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  p_ff, p_in;
   srs_entry_type     prev_ff, prev_in;
   srs_entry_type     cur_ff, cur_in;
   logic              prev_ok_ff, prev_ok_in;
   logic              cur_ok_ff, cur_ok_in;
   logic [DATA_W-1:0] low_ff, low_in;
   logic [DATA_W-1:0] high_ff, high_in;
   logic              drop_ff, drop_in;
   logic              valid_ff, valid_in;

   logic                accept;
   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   srs_entry_type       ram_wdata;
   logic                ram_re;
   logic [ADDR_W-1:0]   ram_raddr;
   logic [ENTRY_W-1:0]  ram_rdata;
   srs_entry_type       rd_entry;
   logic [DATA_W-1:0]   cmp_start;
   logic [DATA_W-1:0]   cmp_stop;
   srs_cmp_type         flags;

   logic covered, lo_adj, hi_adj, slot_hit, full;

   assign accept   = start && !busy;
   assign rd_entry = srs_entry_type'(ram_rdata);

   srs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_RANGES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ENTRY_W'(ram_wdata)),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // scan compares the fresh entry, decide compares the two neighbors
   always_comb begin
      if (state_ff == ST_SCAN_CMP) begin
         cmp_start = rd_entry.low;
         cmp_stop  = rd_entry.high;
      end else begin
         cmp_start = cur_ff.low;
         cmp_stop  = prev_ff.high;
      end
   end

   srs_cmp u_cmp (
      .index_value (v_ff),
      .range_start (cmp_start),
      .range_stop  (cmp_stop),
      .flags       (flags)
   );

   assign covered  = prev_ok_ff && flags.high_ge;
   assign lo_adj   = prev_ok_ff && flags.high_next;
   assign hi_adj   = cur_ok_ff && flags.start_next;
   assign full     = (count_ff >= CNT_W'(MAX_RANGES));
   assign slot_hit = (32'(slot_ff) < 32'(count_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      v_ff       <= v_in;
      slot_ff    <= slot_in;
      idx_ff     <= idx_in;
      p_ff       <= p_in;
      prev_ff    <= prev_in;
      cur_ff     <= cur_in;
      prev_ok_ff <= prev_ok_in;
      cur_ok_ff  <= cur_ok_in;
      low_ff     <= low_in;
      high_ff    <= high_in;
      drop_ff    <= drop_in;
      valid_ff   <= valid_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_func)
                  FUNC_ADD:  state_in = ST_SCAN_RD;
                  FUNC_READ: state_in = ST_READ_RD;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_SCAN_RD: begin
            state_in = (idx_ff >= count_ff) ? ST_DECIDE : ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            state_in = flags.start_le ? ST_SCAN_RD : ST_DECIDE;
         end
         ST_DECIDE: begin
            if (covered) begin
               state_in = ST_DONE;
            end else if (lo_adj && hi_adj) begin
               state_in = ST_SHDN_RD;
            end else if (lo_adj || hi_adj || full) begin
               state_in = ST_DONE;
            end else if (p_ff == count_ff) begin
               state_in = ST_INS;
            end else begin
               state_in = ST_SHUP_RD;
            end
         end
         ST_SHUP_RD:   state_in = ST_SHUP_WR;
         ST_SHUP_WR:   state_in = (idx_ff == p_ff) ? ST_INS : ST_SHUP_RD;
         ST_INS:       state_in = ST_DONE;
         ST_SHDN_RD:   state_in = (idx_ff >= count_ff) ? ST_DONE : ST_SHDN_WR;
         ST_SHDN_WR:   state_in = ST_SHDN_RD;
         ST_READ_RD:   state_in = slot_hit ? ST_READ_WAIT : ST_DONE;
         ST_READ_WAIT: state_in = ST_DONE;
         ST_DONE:      state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath registers
   always_comb begin
      func_in    = func_ff;
      v_in       = v_ff;
      slot_in    = slot_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      p_in       = p_ff;
      prev_in    = prev_ff;
      cur_in     = cur_ff;
      prev_ok_in = prev_ok_ff;
      cur_ok_in  = cur_ok_ff;
      low_in     = low_ff;
      high_in    = high_ff;
      drop_in    = drop_ff;
      valid_in   = valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in    = req_func;
               v_in       = req_index_value;
               slot_in    = req_slot;
               idx_in     = '0;
               prev_ok_in = 1'b0;
               cur_ok_in  = 1'b0;
               low_in     = '0;
               high_in    = '0;
               drop_in    = 1'b0;
               valid_in   = 1'b0;
               if (req_func == FUNC_CLEAR) begin
                  count_in = '0;
               end
            end
         end
         ST_SCAN_RD: begin
            if (idx_ff >= count_ff) begin
               p_in = idx_ff;
            end
         end
         ST_SCAN_CMP: begin
            if (flags.start_le) begin
               prev_in    = rd_entry;
               prev_ok_in = 1'b1;
               idx_in     = idx_ff + CNT_W'(1);
            end else begin
               cur_in    = rd_entry;
               cur_ok_in = 1'b1;
               p_in      = idx_ff;
            end
         end
         ST_DECIDE: begin
            if (!covered) begin
               if (lo_adj && hi_adj) begin
                  idx_in = p_ff + CNT_W'(1);
               end else if (!lo_adj && !hi_adj) begin
                  if (full) begin
                     drop_in = 1'b1;
                  end else begin
                     idx_in = count_ff - CNT_W'(1);
                  end
               end
            end
         end
         ST_SHUP_WR: begin
            idx_in = idx_ff - CNT_W'(1);
         end
         ST_INS: begin
            count_in = count_ff + CNT_W'(1);
         end
         ST_SHDN_RD: begin
            if (idx_ff >= count_ff) begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         ST_SHDN_WR: begin
            idx_in = idx_ff + CNT_W'(1);
         end
         ST_READ_WAIT: begin
            low_in   = rd_entry.low;
            high_in  = rd_entry.high;
            valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // RAM control
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = rd_entry;
      ram_re    = 1'b0;
      ram_raddr = idx_ff[ADDR_W-1:0];
      unique case (state_ff)
         ST_SCAN_RD: begin
            ram_re = (idx_ff < count_ff);
         end
         ST_DECIDE: begin
            if (!covered) begin
               if (lo_adj) begin
                  ram_we         = 1'b1;
                  ram_waddr      = ADDR_W'(p_ff - CNT_W'(1));
                  ram_wdata.low  = prev_ff.low;
                  ram_wdata.high = hi_adj ? cur_ff.high : v_ff;
               end else if (hi_adj) begin
                  ram_we         = 1'b1;
                  ram_waddr      = p_ff[ADDR_W-1:0];
                  ram_wdata.low  = v_ff;
                  ram_wdata.high = cur_ff.high;
               end
            end
         end
         ST_SHUP_RD: begin
            ram_re = 1'b1;
         end
         ST_SHUP_WR: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff[ADDR_W-1:0] + ADDR_W'(1);
         end
         ST_INS: begin
            ram_we         = 1'b1;
            ram_waddr      = p_ff[ADDR_W-1:0];
            ram_wdata.low  = v_ff;
            ram_wdata.high = v_ff;
         end
         ST_SHDN_RD: begin
            ram_re = (idx_ff < count_ff);
         end
         ST_SHDN_WR: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff[ADDR_W-1:0] - ADDR_W'(1);
         end
         ST_READ_RD: begin
            ram_re    = slot_hit;
            ram_raddr = ADDR_W'(slot_ff);
         end
         default: begin
         end
      endcase
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = (state_ff == ST_DONE);
   assign rsp_range_low   = low_ff;
   assign rsp_range_high  = high_ff;
   assign rsp_range_count = count_ff;
   assign rsp_dropped     = drop_ff;
   assign rsp_slot_valid  = valid_ff;

endmodule

`default_nettype wire

// ===== rtl/core/srs_chk.sv =====
// ----------------------------------------------------------------------------
// srs_chk: port-level checks for the sorted range set
// Command and result behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_chk (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       start,
   input wire logic                       busy,
   input wire logic                       rsp_strobe,
   input wire logic [srs_pkg::DATA_W-1:0] rsp_range_low,
   input wire logic [srs_pkg::DATA_W-1:0] rsp_range_high,
   input wire logic [srs_pkg::CNT_W-1:0]  rsp_range_count,
   input wire logic                       rsp_dropped,
   input wire logic                       rsp_slot_valid
);
   import srs_pkg::*;

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transfer did not raise busy");

   a_strobe_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe outside a busy period");

   a_strobe_single : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe && !busy)
      else $error("result strobe longer than one cycle");

   a_read_miss_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_slot_valid |-> rsp_range_low == '0 && rsp_range_high == '0)
      else $error("range fields nonzero without a valid slot");

   a_drop_full : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_dropped |-> rsp_range_count == CNT_W'(MAX_RANGES))
      else $error("drop flagged while the list is not full");

endmodule

bind sorted_range_set_insert srs_chk u_srs_chk (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_range_low   (rsp_range_low),
   .rsp_range_high  (rsp_range_high),
   .rsp_range_count (rsp_range_count),
   .rsp_dropped     (rsp_dropped),
   .rsp_slot_valid  (rsp_slot_valid)
);

`default_nettype wire
